// ===== hdl/assert_macros.svh =====
// assertion macros shared by the convolution rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// concurrent property check on a clock with an active low reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be true
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== hdl/imconv_pkg.sv =====
// shared constants, register map and types of the 3x3 convolution
`timescale 1ns / 1ps
`default_nettype none

package imconv_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned ColW        = $clog2(MaxWidth);
  localparam int unsigned WidthW      = ColW + 1;
  localparam int unsigned HeightW     = 16;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned MaxChannels = 4;
  localparam int unsigned SampleW     = 8;
  localparam int unsigned PixW        = SampleW * MaxChannels;
  localparam int unsigned CoefW       = 16;
  localparam int unsigned FracBits    = 12;
  localparam int unsigned Taps        = 9;

  // emitted pixel count stays below 1024 * 65535
  localparam int unsigned EmitW   = 26;
  localparam int unsigned DivCntW = $clog2(EmitW);

  // lane arithmetic widths
  localparam int unsigned ProdW = SampleW + CoefW;
  localparam int unsigned RowW  = ProdW + 2;
  localparam int unsigned SumW  = RowW + 2;

  // configuration port
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] RegImageWidth   = 3'd0;
  localparam logic [RegIdxW-1:0] RegImageHeight  = 3'd1;
  localparam logic [RegIdxW-1:0] RegChannelCount = 3'd2;
  localparam logic [RegIdxW-1:0] RegCoefFirst    = 3'd3;
  localparam logic [RegIdxW-1:0] RegCoefNext     = 3'd4;
  localparam logic [RegIdxW-1:0] RegCoefLast     = 3'd5;

  localparam logic [WidthW-1:0]   ResetImageWidth   = 11'd640;
  localparam logic [HeightW-1:0]  ResetImageHeight  = 16'd480;
  localparam logic [ChanW-1:0]    ResetChannelCount = 3'd3;
  localparam logic [CfgDataW-1:0] ResetCoefQuad     = 64'h01C7_01C7_01C7_01C7;
  localparam logic [CoefW-1:0]    ResetCoefLast     = 16'h01C7;

  typedef logic [PixW-1:0]    pixel_t;
  typedef pixel_t [Taps-1:0]  window_t;
  typedef logic [SampleW-1:0] sample_t;
  typedef sample_t [Taps-1:0] tap_samples_t;
  typedef logic [CoefW-1:0]   coef_t;
  typedef coef_t [Taps-1:0]   coefs_t;
  typedef logic [Taps-1:0]    tap_mask_t;

  typedef struct packed {
    logic      emit;
    logic      last;
    tap_mask_t mask;
  } ctrl_info_t;

  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } lane_en_t;

endpackage

`default_nettype wire

// ===== hdl/imconv_ctrl.sv =====
// raster position, output position and border masks, with a serial divider for width changes
`timescale 1ns / 1ps
`default_nettype none

module imconv_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             restart_i,
  input  logic [imconv_pkg::WidthW-1:0]    w_i,
  input  logic [imconv_pkg::HeightW-1:0]   h_i,
  output logic                             busy_o,
  output logic [imconv_pkg::ColW-1:0]      col_o,
  output imconv_pkg::ctrl_info_t           info_o
);
  import imconv_pkg::*;

  logic [ColW-1:0]    col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  logic [EmitW-1:0]   emitted_q, emitted_d;
  logic [ColW-1:0]    ox_q, ox_d;
  logic [HeightW-1:0] oy_q, oy_d;
  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [EmitW-1:0]   div_sh_q;
  logic [ColW-1:0]    rem_q;

  logic [WidthW-1:0]  col_inc, ox_inc;
  logic [HeightW:0]   oy_inc;
  logic [HeightW-1:0] row_sat, oy_sat;
  logic               col_wrap, ox_wrap, emit, last;
  logic               top_m, bot_m, left_m, right_m;
  tap_mask_t          mask;

  logic [WidthW-1:0]  rem_sh, rem_sub;
  logic               rem_ge;
  logic [ColW-1:0]    rem_n;
  logic [EmitW-1:0]   quo_n;
  logic [HeightW-1:0] quo_sat;

  always_comb begin
    col_inc  = {1'b0, col_q} + WidthW'(1);
    col_wrap = col_inc >= w_i;
    row_sat  = (row_q != '1) ? row_q + HeightW'(1) : row_q;
    emit     = (row_q > HeightW'(1)) || (row_q == HeightW'(1) && col_q != '0);

    ox_inc  = {1'b0, ox_q} + WidthW'(1);
    ox_wrap = ox_inc >= w_i;
    oy_inc  = {1'b0, oy_q} + (HeightW + 1)'(1);
    oy_sat  = (oy_q != '1) ? oy_q + HeightW'(1) : oy_q;

    top_m   = oy_q == '0;
    bot_m   = oy_inc >= {1'b0, h_i};
    left_m  = ox_q == '0;
    right_m = ox_wrap;
    // ox always stays below the width, so this matches emitted + 1 >= width * height
    last    = (oy_q >= h_i) || (oy_inc == {1'b0, h_i} && ox_wrap);

    for (int t = 0; t < Taps; t++) begin
      mask[t] = !((t < 3 && top_m) || (t >= 6 && bot_m) ||
                  (t % 3 == 0 && left_m) || (t % 3 == 2 && right_m));
    end
  end

  // one restoring division step of emitted count by width
  always_comb begin
    rem_sh  = {rem_q, div_sh_q[EmitW-1]};
    rem_ge  = rem_sh >= w_i;
    rem_sub = rem_sh - w_i;
    rem_n   = rem_ge ? rem_sub[ColW-1:0] : rem_sh[ColW-1:0];
    quo_n   = {div_sh_q[EmitW-2:0], rem_ge};
    quo_sat = (|quo_n[EmitW-1:HeightW]) ? '1 : quo_n[HeightW-1:0];
  end

  always_comb begin
    col_d     = col_wrap ? '0 : col_inc[ColW-1:0];
    row_d     = col_wrap ? row_sat : row_q;
    emitted_d = emitted_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    if (emit) begin
      emitted_d = emitted_q + EmitW'(1);
      ox_d      = ox_wrap ? '0 : ox_inc[ColW-1:0];
      oy_d      = ox_wrap ? oy_sat : oy_q;
      if (last) begin
        col_d     = '0;
        row_d     = '0;
        emitted_d = '0;
        ox_d      = '0;
        oy_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      emitted_q <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      div_sh_q  <= '0;
      rem_q     <= '0;
    end else if (restart_i) begin
      busy_q   <= 1'b1;
      cnt_q    <= '0;
      div_sh_q <= emitted_q;
      rem_q    <= '0;
    end else if (busy_q) begin
      cnt_q    <= cnt_q + DivCntW'(1);
      div_sh_q <= quo_n;
      rem_q    <= rem_n;
      if (cnt_q == DivCntW'(EmitW - 1)) begin
        busy_q <= 1'b0;
        ox_q   <= rem_n;
        oy_q   <= quo_sat;
      end
    end else if (accept_i) begin
      col_q     <= col_d;
      row_q     <= row_d;
      emitted_q <= emitted_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
    end
  end

  assign busy_o      = busy_q;
  assign col_o       = col_q;
  assign info_o.emit = emit;
  assign info_o.last = last;
  assign info_o.mask = mask;

endmodule

`default_nettype wire

// ===== hdl/imconv_linebuf.sv =====
// two-row line memory with write forwarding and the 3x3 pixel window
`timescale 1ns / 1ps
`default_nettype none

module imconv_linebuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [imconv_pkg::ColW-1:0] rd_addr_i,
  input  imconv_pkg::pixel_t          pix_i,
  input  logic                        commit_i,
  output imconv_pkg::window_t         window_o
);
  import imconv_pkg::*;

  // upper row in the high half, middle row in the low half
  logic [2*PixW-1:0] line_mem [MaxWidth];
  logic [2*PixW-1:0] rd_q, fwd_data_q;
  logic              fwd_q;
  logic [ColW-1:0]   col_q;
  pixel_t            pix_q;
  pixel_t            top_res, mid_res;
  window_t           win_q, win_d;

  always_comb begin
    top_res = fwd_q ? fwd_data_q[2*PixW-1:PixW] : rd_q[2*PixW-1:PixW];
    mid_res = fwd_q ? fwd_data_q[PixW-1:0] : rd_q[PixW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= line_mem[rd_addr_i];
      col_q      <= rd_addr_i;
      pix_q      <= pix_i;
      fwd_data_q <= {mid_res, pix_q};
    end
    if (commit_i) begin
      line_mem[col_q] <= {mid_res, pix_q};
    end
  end

  // read of the column being written in the same cycle takes the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= commit_i && (rd_addr_i == col_q);
    end
  end

  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = top_res;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = mid_res;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (commit_i) begin
      win_q <= win_d;
    end
  end

  assign window_o = win_q;

endmodule

`default_nettype wire

// ===== hdl/imconv_lane.sv =====
// one channel lane: nine tap products, row sums, truncation and saturation
`timescale 1ns / 1ps
`default_nettype none

module imconv_lane (
  input  logic                       clk_i,
  input  imconv_pkg::lane_en_t       en_i,
  input  imconv_pkg::tap_samples_t   samples_i,
  input  imconv_pkg::coefs_t         coefs_i,
  output imconv_pkg::sample_t        value_o,
  output logic                       clip_o
);
  import imconv_pkg::*;

  logic signed [ProdW-1:0] full_d [Taps];
  logic signed [ProdW-1:0] prod_q [Taps];
  logic signed [RowW-1:0]  row_d  [3];
  logic signed [RowW-1:0]  row_q  [3];
  logic signed [SumW-1:0]  sum, biased, quo;
  logic                    neg, over;

  always_comb begin
    for (int t = 0; t < Taps; t++) begin
      full_d[t] = $signed({1'b0, samples_i[t]}) * $signed(coefs_i[t]);
    end
    for (int r = 0; r < 3; r++) begin
      row_d[r] = RowW'(prod_q[3*r]) + RowW'(prod_q[3*r+1]) + RowW'(prod_q[3*r+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load_prod) begin
      for (int t = 0; t < Taps; t++) begin
        prod_q[t] <= full_d[t];
      end
    end
    if (en_i.load_sum) begin
      for (int r = 0; r < 3; r++) begin
        row_q[r] <= row_d[r];
      end
    end
  end

  // divide by 2^FracBits rounding toward zero, then clamp to 0..255
  always_comb begin
    sum     = SumW'(row_q[0]) + SumW'(row_q[1]) + SumW'(row_q[2]);
    biased  = sum + $signed({{(SumW-FracBits){1'b0}}, {FracBits{sum[SumW-1]}}});
    quo     = biased >>> FracBits;
    neg     = quo[SumW-1];
    over    = !neg && (|quo[SumW-2:SampleW]);
    clip_o  = neg || over;
    value_o = neg ? '0 : (over ? '1 : quo[SampleW-1:0]);
  end

endmodule

`default_nettype wire

// ===== hdl/image_convolution_3x3.sv =====
// image_convolution_3x3: zero-padded 3x3 convolution of up to four 8-bit channels per pixel
// an input passes the line read, window, tap product, row sum and output registers to its result
// throughput: one pixel per cycle while out_ready_i is high and the divider is idle, set by the
// four-lane multiply pipeline and the line memory that reads and writes one column each cycle
// a write to image_width holds in_ready_o low while the output position divider runs
// reset: asynchronous, active low; loads configuration defaults, clears counters, window and pipeline valids
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module image_convolution_3x3 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [imconv_pkg::CfgAddrW-1:0] paddr,
  input  logic [imconv_pkg::CfgDataW-1:0] pwdata,
  output logic [imconv_pkg::CfgDataW-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [7:0]                      sample_zero_i,
  input  logic [7:0]                      sample_one_i,
  input  logic [7:0]                      sample_two_i,
  input  logic [7:0]                      sample_three_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_zero_o,
  output logic [7:0]                      out_one_o,
  output logic [7:0]                      out_two_o,
  output logic [7:0]                      out_three_o,
  output logic                            frame_last_o,
  output logic                            clipped_o
);
  import imconv_pkg::*;

  // configuration registers
  logic [WidthW-1:0]   image_width_q;
  logic [HeightW-1:0]  image_height_q;
  logic [ChanW-1:0]    channel_count_q;
  logic [CfgDataW-1:0] coef_first_q, coef_next_q;
  logic [CoefW-1:0]    coef_last_q;
  logic                wr_en, width_write;
  logic [RegIdxW-1:0]  reg_idx;

  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [ChanW-1:0]   nch_eff;
  coefs_t             coefs;

  // pipeline control
  logic       accept, leave1, adv2, adv3, adv4;
  logic       s2_free, s3_free, s4_free, out_free;
  logic       v1_q, v2_q, v3_q, v4_q;
  logic       emit1_q, last1_q, last2_q, last3_q, last4_q;
  tap_mask_t  mask1_q, mask2_q;
  logic       div_busy;
  logic [ColW-1:0] col_addr;
  ctrl_info_t info;
  pixel_t     pix_in;
  window_t    window;
  lane_en_t   lane_en;

  tap_samples_t         lane_samples [MaxChannels];
  sample_t              lane_val [MaxChannels];
  logic [MaxChannels-1:0] lane_clip;

  logic    out_valid_q, out_last_q, out_clip_q;
  sample_t out_val_q [MaxChannels];

  assign reg_idx     = paddr[CfgAddrW-1:CfgAddrW-RegIdxW];
  assign wr_en       = psel && penable && pwrite;
  assign width_write = wr_en && (reg_idx == RegImageWidth);
  assign pready      = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= ResetImageWidth;
      image_height_q  <= ResetImageHeight;
      channel_count_q <= ResetChannelCount;
      coef_first_q    <= ResetCoefQuad;
      coef_next_q     <= ResetCoefQuad;
      coef_last_q     <= ResetCoefLast;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegImageWidth:   image_width_q   <= pwdata[WidthW-1:0];
        RegImageHeight:  image_height_q  <= pwdata[HeightW-1:0];
        RegChannelCount: channel_count_q <= pwdata[ChanW-1:0];
        RegCoefFirst:    coef_first_q    <= pwdata;
        RegCoefNext:     coef_next_q     <= pwdata;
        RegCoefLast:     coef_last_q     <= pwdata[CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegImageWidth:   prdata = CfgDataW'(image_width_q);
      RegImageHeight:  prdata = CfgDataW'(image_height_q);
      RegChannelCount: prdata = CfgDataW'(channel_count_q);
      RegCoefFirst:    prdata = coef_first_q;
      RegCoefNext:     prdata = coef_next_q;
      RegCoefLast:     prdata = CfgDataW'(coef_last_q);
      default:         prdata = '0;
    endcase
  end

  // register values outside the legal range are clamped
  always_comb begin
    if (image_width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (image_width_q > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = image_width_q;
    end
    h_eff = (image_height_q == '0) ? HeightW'(1) : image_height_q;
    if (channel_count_q == '0) begin
      nch_eff = ChanW'(1);
    end else if (channel_count_q > ChanW'(MaxChannels)) begin
      nch_eff = ChanW'(MaxChannels);
    end else begin
      nch_eff = channel_count_q;
    end
    for (int t = 0; t < 4; t++) begin
      coefs[t]     = coef_first_q[CoefW*t +: CoefW];
      coefs[t + 4] = coef_next_q[CoefW*t +: CoefW];
    end
    coefs[8] = coef_last_q;
  end

  // stage ready chain from the output register back to the input
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv4       = v4_q && out_free;
  assign s4_free    = !v4_q || out_free;
  assign adv3       = v3_q && s4_free;
  assign s3_free    = !v3_q || s4_free;
  assign adv2       = v2_q && s3_free;
  assign s2_free    = !v2_q || s3_free;
  // every pixel shifts the window, so it waits for the window stage to be free
  assign leave1     = v1_q && s2_free;
  assign in_ready_o = !div_busy && (!v1_q || leave1);
  assign accept     = in_valid_i && in_ready_o;

  // a flush tick enters a black pixel
  assign pix_in = command_i ? '0 : {sample_three_i, sample_two_i, sample_one_i, sample_zero_i};

  imconv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (width_write),
    .w_i       (w_eff),
    .h_i       (h_eff),
    .busy_o    (div_busy),
    .col_o     (col_addr),
    .info_o    (info)
  );

  imconv_linebuf u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_addr),
    .pix_i     (pix_in),
    .commit_i  (leave1),
    .window_o  (window)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (leave1) begin
        v1_q <= 1'b0;
      end
      if (leave1) begin
        v2_q <= emit1_q;
      end else if (adv2) begin
        v2_q <= 1'b0;
      end
      if (adv2) begin
        v3_q <= 1'b1;
      end else if (adv3) begin
        v3_q <= 1'b0;
      end
      if (adv3) begin
        v4_q <= 1'b1;
      end else if (adv4) begin
        v4_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      emit1_q <= info.emit;
      last1_q <= info.last;
      mask1_q <= info.mask;
    end
    if (leave1) begin
      last2_q <= last1_q;
      mask2_q <= mask1_q;
    end
    if (adv2) begin
      last3_q <= last2_q;
    end
    if (adv3) begin
      last4_q <= last3_q;
    end
  end

  // masked border taps and unused channels feed zeros into the lanes
  always_comb begin
    for (int ch = 0; ch < MaxChannels; ch++) begin
      for (int t = 0; t < Taps; t++) begin
        lane_samples[ch][t] = (mask2_q[t] && (ChanW'(ch) < nch_eff)) ?
                              window[t][SampleW*ch +: SampleW] : '0;
      end
    end
  end

  assign lane_en.load_prod = adv2;
  assign lane_en.load_sum  = adv3;

  for (genvar ch = 0; ch < MaxChannels; ch++) begin : g_lane
    imconv_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (lane_en),
      .samples_i (lane_samples[ch]),
      .coefs_i   (coefs),
      .value_o   (lane_val[ch]),
      .clip_o    (lane_clip[ch])
    );
  end

  // merge the lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv4) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      out_last_q <= last4_q;
      out_clip_q <= |lane_clip;
      for (int ch = 0; ch < MaxChannels; ch++) begin
        out_val_q[ch] <= lane_val[ch];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_zero_o   = out_val_q[0];
  assign out_one_o    = out_val_q[1];
  assign out_two_o    = out_val_q[2];
  assign out_three_o  = out_val_q[3];
  assign frame_last_o = out_last_q;
  assign clipped_o    = out_clip_q;

  `ASSERT_PROP(a_window_held, clk_i, rst_ni, v2_q && !adv2 |=> $stable(window), "window moved")
  `ASSERT_PROP(a_sum_kept, clk_i, rst_ni, v4_q && !adv4 |=> v4_q && $stable(last4_q), "lost item")
  `ASSERT_PROP(a_out_loaded, clk_i, rst_ni, adv4 |=> out_valid_o, "result not loaded")
  `ASSERT_NEVER(a_s1_overrun, clk_i, rst_ni, accept && v1_q && !leave1, "read stage overrun")

endmodule

`default_nettype wire
